// ===== src/acp_pkg.sv =====
package acp_pkg;

   // memory size, a power of two so that addresses wrap by truncation
   localparam int MEM_WORDS = 1024;
   localparam int MEM_AW    = $clog2(MEM_WORDS);

   // fixed field widths
   localparam int WORD_W  = 32;
   localparam int PORT_AW = 10;
   localparam int OPC_W   = 4;
   localparam int OPND_W  = 28;
   localparam int UPC_W   = 4;

   // request operations
   localparam logic [1:0] OPER_WRITE   = 2'd0;
   localparam logic [1:0] OPER_READ    = 2'd1;
   localparam logic [1:0] OPER_EXEC    = 2'd2;
   localparam logic [1:0] OPER_RESTART = 2'd3;

   // opcodes
   localparam logic [OPC_W-1:0] OP_LDA = 4'd0;
   localparam logic [OPC_W-1:0] OP_LEA = 4'd1;
   localparam logic [OPC_W-1:0] OP_LDI = 4'd2;
   localparam logic [OPC_W-1:0] OP_STR = 4'd3;
   localparam logic [OPC_W-1:0] OP_STA = 4'd4;
   localparam logic [OPC_W-1:0] OP_ADD = 4'd5;
   localparam logic [OPC_W-1:0] OP_OR  = 4'd6;
   localparam logic [OPC_W-1:0] OP_NOT = 4'd7;
   localparam logic [OPC_W-1:0] OP_SUB = 4'd8;
   localparam logic [OPC_W-1:0] OP_AND = 4'd9;
   localparam logic [OPC_W-1:0] OP_JMP = 4'd10;
   localparam logic [OPC_W-1:0] OP_JEZ = 4'd11;
   localparam logic [OPC_W-1:0] OP_JGZ = 4'd12;
   localparam logic [OPC_W-1:0] OP_JNE = 4'd13;
   localparam logic [OPC_W-1:0] OP_HLT = 4'd14;

   // condition flag codes
   localparam logic [1:0] FLAG_POS  = 2'd0;
   localparam logic [1:0] FLAG_NEG  = 2'd1;
   localparam logic [1:0] FLAG_ZERO = 2'd2;

   // run status codes
   localparam logic [1:0] ST_RUN  = 2'd0;
   localparam logic [1:0] ST_HALT = 2'd1;
   localparam logic [1:0] ST_ERR  = 2'd2;

   // microprogram step addresses
   localparam logic [UPC_W-1:0] U_WRITE   = 4'd0;
   localparam logic [UPC_W-1:0] U_READ    = 4'd1;
   localparam logic [UPC_W-1:0] U_READ2   = 4'd2;
   localparam logic [UPC_W-1:0] U_RESTART = 4'd3;
   localparam logic [UPC_W-1:0] U_FETCH   = 4'd4;
   localparam logic [UPC_W-1:0] U_DECODE  = 4'd5;
   localparam logic [UPC_W-1:0] U_LDA     = 4'd6;
   localparam logic [UPC_W-1:0] U_PTR     = 4'd7;
   localparam logic [UPC_W-1:0] U_LDI     = 4'd8;
   localparam logic [UPC_W-1:0] U_STR     = 4'd9;
   localparam logic [UPC_W-1:0] U_STA     = 4'd10;
   localparam logic [UPC_W-1:0] U_ALU     = 4'd11;
   localparam logic [UPC_W-1:0] U_JMP     = 4'd12;
   localparam logic [UPC_W-1:0] U_HLT     = 4'd13;
   localparam logic [UPC_W-1:0] U_ERR     = 4'd14;
   localparam logic [UPC_W-1:0] U_NOP     = 4'd15;

   // control word fields
   typedef enum logic [2:0] {A_NONE, A_REQ, A_PC, A_RDATA, A_IR} addr_sel_type;
   typedef enum logic {W_REQ, W_ACC} wdata_sel_type;
   typedef enum logic [1:0] {PC_KEEP, PC_INC, PC_START, PC_JUMP} pc_op_type;
   typedef enum logic [2:0] {ACC_KEEP, ACC_MEM, ACC_IMM, ACC_ALU, ACC_CLEAR} acc_op_type;
   typedef enum logic [1:0] {FL_KEEP, FL_SET, FL_CLEAR} flag_op_type;
   typedef enum logic [1:0] {SO_KEEP, SO_HALT, SO_ERR, SO_CLEAR} st_op_type;
   typedef enum logic [1:0] {RD_KEEP, RD_LOAD, RD_CLEAR} rd_op_type;
   typedef enum logic [1:0] {SEQ_NEXT, SEQ_DISPATCH, SEQ_DONE} seq_op_type;

   typedef struct packed {
      addr_sel_type    addr_sel;
      logic            mem_we;
      wdata_sel_type   wdata_sel;
      logic            ir_ld;
      pc_op_type       pc_op;
      acc_op_type      acc_op;
      flag_op_type     flag_op;
      st_op_type       st_op;
      rd_op_type       rd_op;
      seq_op_type      seq_op;
      logic [UPC_W-1:0] target;
   } ctrl_type;

   // status from datapath back to the sequencer
   typedef struct packed {
      logic             running;
      logic             clearing;
      logic [OPC_W-1:0] opcode;
   } dp_stat_type;

   localparam ctrl_type CTRL_IDLE = '{
      addr_sel: A_NONE, mem_we: 1'b0, wdata_sel: W_REQ, ir_ld: 1'b0,
      pc_op: PC_KEEP, acc_op: ACC_KEEP, flag_op: FL_KEEP, st_op: SO_KEEP,
      rd_op: RD_KEEP, seq_op: SEQ_DONE, target: U_NOP};

   // microprogram rom
   function automatic ctrl_type ucode(input logic [UPC_W-1:0] step);
      ctrl_type c;
      c = CTRL_IDLE;
      c.rd_op = RD_CLEAR;
      case (step)
         U_WRITE: begin
            c.addr_sel  = A_REQ;
            c.mem_we    = 1'b1;
            c.wdata_sel = W_REQ;
         end
         U_READ: begin
            c.addr_sel = A_REQ;
            c.seq_op   = SEQ_NEXT;
            c.target   = U_READ2;
         end
         U_READ2: begin
            c.rd_op = RD_LOAD;
         end
         U_RESTART: begin
            c.pc_op   = PC_START;
            c.acc_op  = ACC_CLEAR;
            c.flag_op = FL_CLEAR;
            c.st_op   = SO_CLEAR;
         end
         U_FETCH: begin
            c.addr_sel = A_PC;
            c.seq_op   = SEQ_NEXT;
            c.target   = U_DECODE;
         end
         U_DECODE: begin
            c.addr_sel = A_RDATA;
            c.ir_ld    = 1'b1;
            c.pc_op    = PC_INC;
            c.seq_op   = SEQ_DISPATCH;
         end
         U_LDA: begin
            c.acc_op = ACC_MEM;
         end
         U_PTR: begin
            c.addr_sel = A_RDATA;
            c.seq_op   = SEQ_NEXT;
            c.target   = U_LDA;
         end
         U_LDI: begin
            c.acc_op  = ACC_IMM;
            c.flag_op = FL_SET;
         end
         U_STR: begin
            c.addr_sel  = A_IR;
            c.mem_we    = 1'b1;
            c.wdata_sel = W_ACC;
         end
         U_STA: begin
            c.addr_sel  = A_RDATA;
            c.mem_we    = 1'b1;
            c.wdata_sel = W_ACC;
         end
         U_ALU: begin
            c.acc_op  = ACC_ALU;
            c.flag_op = FL_SET;
         end
         U_JMP: begin
            c.pc_op = PC_JUMP;
         end
         U_HLT: begin
            c.st_op = SO_HALT;
         end
         U_ERR: begin
            c.st_op = SO_ERR;
         end
         default: begin
            c.rd_op = RD_CLEAR;
         end
      endcase
      return c;
   endfunction

   // opcode dispatch after decode
   function automatic logic [UPC_W-1:0] dispatch(input logic [OPC_W-1:0] opc);
      logic [UPC_W-1:0] s;
      case (opc) inside
         OP_LDA:           s = U_LDA;
         OP_LEA:           s = U_PTR;
         OP_LDI:           s = U_LDI;
         OP_STR:           s = U_STR;
         OP_STA:           s = U_STA;
         [OP_ADD:OP_AND]:  s = U_ALU;
         [OP_JMP:OP_JNE]:  s = U_JMP;
         OP_HLT:           s = U_HLT;
         default:          s = U_ERR;
      endcase
      return s;
   endfunction

   // condition flag of an accumulator value
   function automatic logic [1:0] flag_of(input logic [WORD_W-1:0] v);
      logic [1:0] f;
      if (v == '0) begin
         f = FLAG_ZERO;
      end else if (v[WORD_W-1]) begin
         f = FLAG_NEG;
      end else begin
         f = FLAG_POS;
      end
      return f;
   endfunction

endpackage

// ===== src/acp_ram.sv =====
module acp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/acp_useq.sv =====
module acp_useq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [1:0]           operation,
   input  acp_pkg::dp_stat_type stat,
   output acp_pkg::ctrl_type    ctrl,
   output logic                 accept,
   output logic                 busy,
   output logic                 strobe
);
   import acp_pkg::*;

   logic [UPC_W-1:0] upc_ff, upc_in;
   logic             run_ff, run_in;
   logic             strobe_ff, strobe_in;
   logic [UPC_W-1:0] entry;
   ctrl_type         word;

   assign busy   = run_ff | stat.clearing;
   assign accept = start & ~busy;
   assign word   = ucode(upc_ff);
   assign ctrl   = run_ff ? word : CTRL_IDLE;
   assign strobe = strobe_ff;

   // entry step of each request
   always_comb begin
      case (operation)
         OPER_WRITE:   entry = U_WRITE;
         OPER_READ:    entry = U_READ;
         OPER_EXEC:    entry = stat.running ? U_FETCH : U_NOP;
         OPER_RESTART: entry = U_RESTART;
         default:      entry = U_NOP;
      endcase
   end

   // step counter and sequencing
   always_comb begin
      upc_in    = upc_ff;
      run_in    = run_ff;
      strobe_in = 1'b0;
      if (accept) begin
         upc_in = entry;
         run_in = 1'b1;
      end else if (run_ff) begin
         case (word.seq_op)
            SEQ_NEXT:     upc_in = word.target;
            SEQ_DISPATCH: upc_in = dispatch(stat.opcode);
            SEQ_DONE: begin
               run_in    = 1'b0;
               strobe_in = 1'b1;
            end
            default: begin
               run_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff    <= U_NOP;
         run_ff    <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         upc_ff    <= upc_in;
         run_ff    <= run_in;
         strobe_ff <= strobe_in;
      end
   end

endmodule

// ===== src/acp_dpath.sv =====
module acp_dpath (
   input  logic                          clock,
   input  logic                          reset,
   input  acp_pkg::ctrl_type             ctrl,
   input  logic                          accept,
   input  logic [acp_pkg::PORT_AW-1:0]   req_addr,
   input  logic [acp_pkg::WORD_W-1:0]    req_data,
   input  logic                          csr_we,
   input  logic [acp_pkg::PORT_AW-1:0]   csr_data,
   output acp_pkg::dp_stat_type          stat,
   output logic [1:0]                    run_status,
   output logic [acp_pkg::WORD_W-1:0]    accumulator,
   output logic [acp_pkg::PORT_AW-1:0]   program_counter,
   output logic [1:0]                    condition,
   output logic [acp_pkg::WORD_W-1:0]    instruction,
   output logic [acp_pkg::WORD_W-1:0]    read_data
);
   import acp_pkg::*;

   logic [MEM_AW-1:0]  req_addr_ff;
   logic [WORD_W-1:0]  req_data_ff;
   logic [PORT_AW-1:0] start_ff;
   logic [WORD_W-1:0]  acc_ff, acc_in;
   logic [MEM_AW-1:0]  pc_ff, pc_in;
   logic [WORD_W-1:0]  ir_ff, ir_in;
   logic [1:0]         flag_ff, flag_in;
   logic [1:0]         st_ff, st_in;
   logic [WORD_W-1:0]  rd_ff, rd_in;
   logic               clr_ff;
   logic [MEM_AW-1:0]  clr_addr_ff;

   logic [MEM_AW-1:0]  mem_addr;
   logic [WORD_W-1:0]  mem_wdata;
   logic [WORD_W-1:0]  ram_wdata;
   logic [MEM_AW-1:0]  ram_waddr;
   logic               ram_we;
   logic [WORD_W-1:0]  ram_rdata;
   logic [WORD_W-1:0]  alu_out;
   logic [WORD_W-1:0]  imm;
   logic               jump_take;
   logic [OPC_W-1:0]   ir_opc;

   assign ir_opc = ir_ff[WORD_W-1 -: OPC_W];

   // memory address select
   always_comb begin
      case (ctrl.addr_sel)
         A_REQ:   mem_addr = req_addr_ff;
         A_PC:    mem_addr = pc_ff;
         A_RDATA: mem_addr = ram_rdata[MEM_AW-1:0];
         A_IR:    mem_addr = ir_ff[MEM_AW-1:0];
         default: mem_addr = pc_ff;
      endcase
   end

   assign mem_wdata = (ctrl.wdata_sel == W_ACC) ? acc_ff : req_data_ff;

   // clearing pass owns the write port after reset
   assign ram_we    = clr_ff | ctrl.mem_we;
   assign ram_waddr = clr_ff ? clr_addr_ff : mem_addr;
   assign ram_wdata = clr_ff ? '0 : mem_wdata;

   acp_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MEM_WORDS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (mem_addr),
      .rdata (ram_rdata)
   );

   // alu
   always_comb begin
      case (ir_opc)
         OP_ADD:  alu_out = acc_ff + ram_rdata;
         OP_OR:   alu_out = acc_ff | ram_rdata;
         OP_NOT:  alu_out = ~ram_rdata;
         OP_SUB:  alu_out = acc_ff - ram_rdata;
         OP_AND:  alu_out = acc_ff & ram_rdata;
         default: alu_out = ram_rdata;
      endcase
   end

   // sign extended immediate
   assign imm = {{(WORD_W-OPND_W){ir_ff[OPND_W-1]}}, ir_ff[OPND_W-1:0]};

   // jump condition
   always_comb begin
      case (ir_opc)
         OP_JMP:  jump_take = 1'b1;
         OP_JEZ:  jump_take = (flag_ff == FLAG_ZERO);
         OP_JGZ:  jump_take = (flag_ff == FLAG_POS);
         OP_JNE:  jump_take = (flag_ff == FLAG_NEG);
         default: jump_take = 1'b0;
      endcase
   end

   // architectural register updates
   always_comb begin
      case (ctrl.acc_op)
         ACC_MEM:   acc_in = ram_rdata;
         ACC_IMM:   acc_in = imm;
         ACC_ALU:   acc_in = alu_out;
         ACC_CLEAR: acc_in = '0;
         default:   acc_in = acc_ff;
      endcase

      case (ctrl.pc_op)
         PC_INC:   pc_in = pc_ff + MEM_AW'(1);
         PC_START: pc_in = MEM_AW'(start_ff);
         PC_JUMP:  pc_in = jump_take ? ir_ff[MEM_AW-1:0] : pc_ff;
         default:  pc_in = pc_ff;
      endcase

      case (ctrl.flag_op)
         FL_SET:   flag_in = flag_of(acc_in);
         FL_CLEAR: flag_in = FLAG_POS;
         default:  flag_in = flag_ff;
      endcase

      case (ctrl.st_op)
         SO_HALT:  st_in = ST_HALT;
         SO_ERR:   st_in = ST_ERR;
         SO_CLEAR: st_in = ST_RUN;
         default:  st_in = st_ff;
      endcase

      case (ctrl.rd_op)
         RD_LOAD:  rd_in = ram_rdata;
         RD_CLEAR: rd_in = '0;
         default:  rd_in = rd_ff;
      endcase

      ir_in = ctrl.ir_ld ? ram_rdata : ir_ff;
   end

   // request payload capture
   always_ff @(posedge clock) begin
      if (accept) begin
         req_addr_ff <= MEM_AW'(req_addr);
         req_data_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff    <= '0;
         acc_ff      <= '0;
         pc_ff       <= '0;
         ir_ff       <= '0;
         flag_ff     <= FLAG_POS;
         st_ff       <= ST_RUN;
         rd_ff       <= '0;
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         if (csr_we) begin
            start_ff <= csr_data;
         end
         acc_ff  <= acc_in;
         pc_ff   <= pc_in;
         ir_ff   <= ir_in;
         flag_ff <= flag_in;
         st_ff   <= st_in;
         rd_ff   <= rd_in;
         // zero sweep over the memory
         if (clr_ff) begin
            clr_addr_ff <= clr_addr_ff + MEM_AW'(1);
            if (clr_addr_ff == MEM_AW'(MEM_WORDS - 1)) begin
               clr_ff <= 1'b0;
            end
         end
      end
   end

   assign stat.running  = (st_ff == ST_RUN);
   assign stat.clearing = clr_ff;
   assign stat.opcode   = ram_rdata[WORD_W-1 -: OPC_W];

   assign run_status      = st_ff;
   assign accumulator     = acc_ff;
   assign program_counter = PORT_AW'(pc_ff);
   assign condition       = flag_ff;
   assign instruction     = ir_ff;
   assign read_data       = rd_ff;

endmodule

// ===== src/accumulator_cpu_core.sv =====
// 32-bit accumulator processor core with a microcoded sequencer.
// Requests: assert start with req_operation, req_mem_address and req_mem_data;
// the request is taken on a clock edge where start is high and busy is low.
// Operations are memory write, memory read, execute one instruction, restart.
// Each request produces one response: rsp_strobe is high for exactly one
// cycle with the core state (status, accumulator, pc, flag, last instruction)
// and, for a read, the memory word in rsp_read_data (zero otherwise).
// Steps per request: write, restart and an execute while stopped run their own
// step only, read runs read then read2, execute runs fetch, decode and the opcode's
// step, and an indirect load adds a pointer step. Each microprogram step makes one
// access to the synchronous memory, and busy stays high through the strobe edge,
// so the next request is accepted no earlier than the strobe cycle itself.
// The responder cannot be stalled; rsp_strobe is never held.
// csr_start_address sets the pc loaded by restart; it is accepted whenever
// csr_valid is high (csr_ready is always high); write it only while idle.
// Synchronous reset clears the core state, then sweeps zeros through the whole
// memory, one word per cycle, with busy high until done.
module accumulator_cpu_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_operation,
   input  logic [acp_pkg::PORT_AW-1:0] req_mem_address,
   input  logic [acp_pkg::WORD_W-1:0]  req_mem_data,
   output logic                        rsp_strobe,
   output logic [1:0]                  rsp_run_status,
   output logic [acp_pkg::WORD_W-1:0]  rsp_accumulator,
   output logic [acp_pkg::PORT_AW-1:0] rsp_program_counter,
   output logic [1:0]                  rsp_condition,
   output logic [acp_pkg::WORD_W-1:0]  rsp_instruction,
   output logic [acp_pkg::WORD_W-1:0]  rsp_read_data,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [acp_pkg::PORT_AW-1:0] csr_start_address
);
   import acp_pkg::*;

   ctrl_type    ctrl;
   dp_stat_type stat;
   logic        accept;

   assign csr_ready = 1'b1;

   // step sequencer with microcode rom
   acp_useq u_useq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .operation (req_operation),
      .stat      (stat),
      .ctrl      (ctrl),
      .accept    (accept),
      .busy      (busy),
      .strobe    (rsp_strobe)
   );

   // registers, alu and memory
   acp_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .accept          (accept),
      .req_addr        (req_mem_address),
      .req_data        (req_mem_data),
      .csr_we          (csr_valid),
      .csr_data        (csr_start_address),
      .stat            (stat),
      .run_status      (rsp_run_status),
      .accumulator     (rsp_accumulator),
      .program_counter (rsp_program_counter),
      .condition       (rsp_condition),
      .instruction     (rsp_instruction),
      .read_data       (rsp_read_data)
   );

endmodule

// ===== tb/core_monitor.sv =====
`timescale 1ns / 1ps

module core_monitor (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        busy,
   input  logic [1:0]                  req_operation,
   input  logic [acp_pkg::PORT_AW-1:0] req_mem_address,
   input  logic [acp_pkg::WORD_W-1:0]  req_mem_data,
   input  logic                        rsp_strobe,
   input  logic [1:0]                  rsp_run_status,
   input  logic [acp_pkg::WORD_W-1:0]  rsp_accumulator,
   input  logic [acp_pkg::PORT_AW-1:0] rsp_program_counter,
   input  logic [1:0]                  rsp_condition,
   input  logic [acp_pkg::WORD_W-1:0]  rsp_instruction,
   input  logic [acp_pkg::WORD_W-1:0]  rsp_read_data,
   input  logic                        csr_valid,
   input  logic                        csr_ready,
   input  logic [acp_pkg::PORT_AW-1:0] csr_start_address,
   output int                          outstanding,
   output int                          fail_count
);
   import acp_pkg::*;

   // core state as seen on the response ports
   typedef struct packed {
      logic [1:0]         status;
      logic [WORD_W-1:0]  acc;
      logic [PORT_AW-1:0] pc;
      logic [1:0]         cond;
      logic [WORD_W-1:0]  instr;
      logic [WORD_W-1:0]  rdata;
   } core_view_type;

   // shadow copy of the core
   logic [WORD_W-1:0]  shadow_mem [0:MEM_WORDS-1];
   logic [WORD_W-1:0]  shadow_acc;
   logic [PORT_AW-1:0] shadow_pc;
   logic [WORD_W-1:0]  shadow_ir;
   logic [1:0]         shadow_cond;
   logic [1:0]         shadow_status;
   logic [PORT_AW-1:0] shadow_start;

   core_view_type core_views_due [$];

   function automatic logic [1:0] sign_class(input logic [WORD_W-1:0] v);
      logic [1:0] c;
      if (v == '0) begin
         c = FLAG_ZERO;
      end else if (v[WORD_W-1]) begin
         c = FLAG_NEG;
      end else begin
         c = FLAG_POS;
      end
      return c;
   endfunction

   task automatic clear_shadow();
      for (int i = 0; i < MEM_WORDS; i++) begin
         shadow_mem[i] = '0;
      end
      shadow_start  = '0;
      shadow_acc    = '0;
      shadow_pc     = '0;
      shadow_ir     = '0;
      shadow_cond   = FLAG_POS;
      shadow_status = ST_RUN;
   endtask

   // apply one request to the shadow core and return the state it reports
   task automatic run_core_op(input logic [1:0] op, input logic [PORT_AW-1:0] addr,
                              input logic [WORD_W-1:0] data, output core_view_type view);
      logic [WORD_W-1:0] rd;
      logic [WORD_W-1:0] word;
      logic [OPC_W-1:0]  opc;
      logic [OPND_W-1:0] opnd;
      logic              sets_cond;
      rd        = '0;
      sets_cond = 1'b0;
      case (op)
         OPER_WRITE: begin
            shadow_mem[addr] = data;
         end
         OPER_READ: begin
            rd = shadow_mem[addr];
         end
         OPER_EXEC: begin
            // a stopped core ignores execute
            if (shadow_status == ST_RUN) begin
               shadow_ir = shadow_mem[shadow_pc];
               shadow_pc = shadow_pc + PORT_AW'(1);
               opc       = shadow_ir[WORD_W-1 -: OPC_W];
               opnd      = shadow_ir[OPND_W-1:0];
               word      = shadow_mem[opnd[PORT_AW-1:0]];
               case (opc)
                  OP_LDA: shadow_acc = word;
                  OP_LEA: shadow_acc = shadow_mem[word[PORT_AW-1:0]];
                  OP_LDI: begin
                     shadow_acc = {{(WORD_W-OPND_W){opnd[OPND_W-1]}}, opnd};
                     sets_cond  = 1'b1;
                  end
                  OP_STR: shadow_mem[opnd[PORT_AW-1:0]] = shadow_acc;
                  OP_STA: shadow_mem[word[PORT_AW-1:0]] = shadow_acc;
                  OP_ADD: begin
                     shadow_acc = shadow_acc + word;
                     sets_cond  = 1'b1;
                  end
                  OP_OR: begin
                     shadow_acc = shadow_acc | word;
                     sets_cond  = 1'b1;
                  end
                  OP_NOT: begin
                     shadow_acc = ~word;
                     sets_cond  = 1'b1;
                  end
                  OP_SUB: begin
                     shadow_acc = shadow_acc - word;
                     sets_cond  = 1'b1;
                  end
                  OP_AND: begin
                     shadow_acc = shadow_acc & word;
                     sets_cond  = 1'b1;
                  end
                  OP_JMP: shadow_pc = opnd[PORT_AW-1:0];
                  OP_JEZ: if (shadow_cond == FLAG_ZERO) shadow_pc = opnd[PORT_AW-1:0];
                  OP_JGZ: if (shadow_cond == FLAG_POS) shadow_pc = opnd[PORT_AW-1:0];
                  OP_JNE: if (shadow_cond == FLAG_NEG) shadow_pc = opnd[PORT_AW-1:0];
                  OP_HLT: shadow_status = ST_HALT;
                  default: shadow_status = ST_ERR;
               endcase
               if (sets_cond) begin
                  shadow_cond = sign_class(shadow_acc);
               end
            end
         end
         default: begin
            // restart keeps memory and the instruction register
            shadow_pc     = shadow_start;
            shadow_acc    = '0;
            shadow_cond   = FLAG_POS;
            shadow_status = ST_RUN;
         end
      endcase
      view = '{status: shadow_status, acc: shadow_acc, pc: shadow_pc, cond: shadow_cond,
               instr: shadow_ir, rdata: rd};
   endtask

   function automatic int field_off(input string name, input logic [WORD_W-1:0] want,
                                    input logic [WORD_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   // watch responses, configuration writes and requests
   always @(posedge clock) begin : watch
      core_view_type got;
      core_view_type want;
      int            bad;
      bad = 0;
      if (reset) begin
         clear_shadow();
         core_views_due.delete();
      end else begin
         if (rsp_strobe) begin
            got = '{status: rsp_run_status, acc: rsp_accumulator, pc: rsp_program_counter,
                    cond: rsp_condition, instr: rsp_instruction, rdata: rsp_read_data};
            if (core_views_due.size() == 0) begin
               $error("response strobe with no request pending");
               bad++;
            end else begin
               want = core_views_due.pop_front();
               bad += field_off("run_status", WORD_W'(want.status), WORD_W'(got.status));
               bad += field_off("accumulator", want.acc, got.acc);
               bad += field_off("program_counter", WORD_W'(want.pc), WORD_W'(got.pc));
               bad += field_off("condition", WORD_W'(want.cond), WORD_W'(got.cond));
               bad += field_off("instruction", want.instr, got.instr);
               bad += field_off("read_data", want.rdata, got.rdata);
            end
         end
         if (csr_valid && csr_ready) begin
            shadow_start = csr_start_address;
         end
         if (start && !busy) begin
            run_core_op(req_operation, req_mem_address, req_mem_data, want);
            core_views_due.push_back(want);
         end
      end
      outstanding <= core_views_due.size();
      fail_count  <= fail_count + bad;
   end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import acp_pkg::*;

   localparam logic [OPC_W-1:0] OP_BAD = 4'd15;
   localparam int ITEMS_PER_PHASE = 165;

   logic                clock = 1'b0;
   logic                reset;
   logic                start;
   logic                busy;
   logic [1:0]          req_operation;
   logic [PORT_AW-1:0]  req_mem_address;
   logic [WORD_W-1:0]   req_mem_data;
   logic                rsp_strobe;
   logic [1:0]          rsp_run_status;
   logic [WORD_W-1:0]   rsp_accumulator;
   logic [PORT_AW-1:0]  rsp_program_counter;
   logic [1:0]          rsp_condition;
   logic [WORD_W-1:0]   rsp_instruction;
   logic [WORD_W-1:0]   rsp_read_data;
   logic                csr_valid;
   logic                csr_ready;
   logic [PORT_AW-1:0]  csr_start_address;
   int                  outstanding;
   int                  fail_count;

   logic [PORT_AW-1:0]  cur_start;
   logic                burst;
   int                  n_items;

   always #6 clock = ~clock;

   accumulator_cpu_core DUT (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_operation       (req_operation),
      .req_mem_address     (req_mem_address),
      .req_mem_data        (req_mem_data),
      .rsp_strobe          (rsp_strobe),
      .rsp_run_status      (rsp_run_status),
      .rsp_accumulator     (rsp_accumulator),
      .rsp_program_counter (rsp_program_counter),
      .rsp_condition       (rsp_condition),
      .rsp_instruction     (rsp_instruction),
      .rsp_read_data       (rsp_read_data),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_start_address   (csr_start_address)
   );

   core_monitor u_monitor (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_operation       (req_operation),
      .req_mem_address     (req_mem_address),
      .req_mem_data        (req_mem_data),
      .rsp_strobe          (rsp_strobe),
      .rsp_run_status      (rsp_run_status),
      .rsp_accumulator     (rsp_accumulator),
      .rsp_program_counter (rsp_program_counter),
      .rsp_condition       (rsp_condition),
      .rsp_instruction     (rsp_instruction),
      .rsp_read_data       (rsp_read_data),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_start_address   (csr_start_address),
      .outstanding         (outstanding),
      .fail_count          (fail_count)
   );

   // one request: random gap unless in a burst, then hold start until the core takes it
   task automatic issue(input logic [1:0] op, input logic [PORT_AW-1:0] addr,
                        input logic [WORD_W-1:0] data);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start           <= 1'b1;
      req_operation   <= op;
      req_mem_address <= addr;
      req_mem_data    <= data;
      do @(posedge clock); while (busy);
      n_items++;
   endtask

   // stop sending until every response is back
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic set_start_address(input logic [PORT_AW-1:0] value);
      drain();
      csr_valid         <= 1'b1;
      csr_start_address <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_start = value;
   endtask

   // data word with corner values and pointers into the data block
   function automatic logic [WORD_W-1:0] data_word(input logic [PORT_AW-1:0] dbase);
      logic [WORD_W-1:0] w;
      case ($urandom_range(0, 7))
         0: w = '0;
         1: w = 32'h8000_0000;
         2: w = '1;
         3: w = 32'h7fff_ffff;
         default: w = $urandom();
      endcase
      if ($urandom_range(0, 1) == 0) begin
         w[PORT_AW-1:0] = dbase + PORT_AW'($urandom_range(0, 3));
      end
      return w;
   endfunction

   // write a short program at the start address plus its data, restart, run it
   task automatic load_and_run();
      int                 len;
      int                 steps;
      logic [PORT_AW-1:0] dbase;
      logic [OPC_W-1:0]   opc;
      logic [OPND_W-1:0]  opnd;
      len   = $urandom_range(1, 8);
      dbase = PORT_AW'($urandom());
      for (int i = 0; i < 4; i++) begin
         issue(OPER_WRITE, dbase + PORT_AW'(i), data_word(dbase));
      end
      for (int i = 0; i < len; i++) begin
         opc = OPC_W'($urandom_range(0, 15));
         if (opc >= OP_HLT && $urandom_range(0, 2) != 0) begin
            opc = OPC_W'($urandom_range(0, 13));
         end
         opnd = OPND_W'($urandom());
         if (opc >= OP_JMP && opc <= OP_JNE) begin
            opnd[PORT_AW-1:0] = cur_start + PORT_AW'($urandom_range(0, len + 1));
         end else if ($urandom_range(0, 4) != 0) begin
            opnd[PORT_AW-1:0] = dbase + PORT_AW'($urandom_range(0, 3));
         end
         issue(OPER_WRITE, cur_start + PORT_AW'(i), {opc, opnd});
      end
      issue(OPER_RESTART, PORT_AW'($urandom()), $urandom());
      steps = $urandom_range(len, len + 4);
      for (int i = 0; i < steps; i++) begin
         if ($urandom_range(0, 5) == 0) begin
            issue(OPER_READ, dbase + PORT_AW'($urandom_range(0, 3)), $urandom());
         end
         issue(OPER_EXEC, PORT_AW'($urandom()), $urandom());
      end
   endtask

   // unstructured requests
   task automatic stray_requests();
      int count;
      count = $urandom_range(1, 4);
      for (int i = 0; i < count; i++) begin
         issue(2'($urandom_range(0, 3)), PORT_AW'($urandom()), $urandom());
      end
   endtask

   // run time limit
   initial begin
      #3_000_000;
      $display("** accumulator_cpu_core: FAILED **");
      $finish;
   end

   initial begin
      logic [PORT_AW-1:0] phase_start [6];
      int                 phase_items;
      reset             <= 1'b1;
      start             <= 1'b0;
      req_operation     <= OPER_READ;
      req_mem_address   <= '0;
      req_mem_data      <= '0;
      csr_valid         <= 1'b0;
      csr_start_address <= '0;
      cur_start = '0;
      burst     = 1'b0;
      n_items   = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: memory extremes, a short program through halt, error stop
      issue(OPER_READ, 10'd0, '0);
      issue(OPER_WRITE, 10'd1023, 32'hffff_ffff);
      issue(OPER_READ, 10'd1023, '0);
      issue(OPER_WRITE, 10'd0, {OP_LDI, 28'h7ff_ffff});
      issue(OPER_WRITE, 10'd1, {OP_ADD, 28'hfff_ffff});
      issue(OPER_WRITE, 10'd2, {OP_NOT, 28'h000_03ff});
      issue(OPER_WRITE, 10'd3, {OP_JEZ, 28'h000_0006});
      issue(OPER_WRITE, 10'd6, {OP_LEA, 28'h000_03ff});
      issue(OPER_WRITE, 10'd7, {OP_HLT, 28'h000_0000});
      repeat (6) issue(OPER_EXEC, '0, '0);
      // execute while halted does nothing
      issue(OPER_EXEC, '0, '0);
      issue(OPER_WRITE, 10'd0, {OP_BAD, 28'h000_0000});
      issue(OPER_RESTART, '0, '0);
      issue(OPER_EXEC, '0, '0);
      issue(OPER_EXEC, '0, '0);
      issue(OPER_READ, 10'd0, '0);

      // random phases, each under a start address written before it begins
      phase_start[0] = 10'd1023;
      phase_start[1] = PORT_AW'($urandom());
      phase_start[2] = 10'd0;
      phase_start[3] = PORT_AW'($urandom());
      phase_start[4] = 10'd1023;
      phase_start[5] = PORT_AW'($urandom());
      for (int p = 0; p < 6; p++) begin
         set_start_address(phase_start[p]);
         phase_items = n_items;
         while (n_items - phase_items < ITEMS_PER_PHASE) begin
            burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) == 0) begin
               stray_requests();
            end else begin
               load_and_run();
            end
            if ($urandom_range(0, 9) == 0) begin
               drain();
            end
         end
      end

      drain();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("** accumulator_cpu_core: PASSED **");
      end else begin
         $display("** accumulator_cpu_core: FAILED **");
      end
      $finish;
   end

endmodule
